FILE: src/lmss_pkg.sv
// Shared constants, types and reset values for the LED matrix scroll scanner.
`default_nettype none

package lmss_pkg;

   localparam int MATRIX_SIZE     = 8;
   localparam int FRAMES_PER_STEP = 2;
   localparam int FIRST_DWELL     = 3;

   localparam int PIXEL_W  = 8;
   localparam int COL_W    = 3;
   localparam int DWELL_W  = 2;
   localparam int OFFSET_W = 4;
   localparam int INDEX_W  = 4;

   localparam logic [COL_W-1:0]           LAST_COLUMN = COL_W'(MATRIX_SIZE - 1);
   localparam logic signed [OFFSET_W-1:0] MAX_OFFSET  = OFFSET_W'(MATRIX_SIZE - 1);
   localparam logic signed [OFFSET_W-1:0] MIN_OFFSET  = OFFSET_W'(-(MATRIX_SIZE - 1));
   localparam logic [DWELL_W-1:0]         DWELL_RELOAD = DWELL_W'(FRAMES_PER_STEP);
   localparam logic [DWELL_W-1:0]         DWELL_START  = DWELL_W'(FIRST_DWELL);

   typedef logic [MATRIX_SIZE-1:0][PIXEL_W-1:0] pattern_array_type;

   localparam pattern_array_type PATTERN_RESET = {
      8'h66, 8'h66, 8'h66, 8'h7E, 8'h66, 8'h66, 8'h3C, 8'h18
   };

   typedef struct packed {
      logic [PIXEL_W-1:0]           row_drive_n;
      logic [MATRIX_SIZE-1:0]       column_enable_n;
      logic [COL_W-1:0]             active_column;
      logic signed [OFFSET_W-1:0]   current_offset;
   } result_type;

endpackage

`default_nettype wire

FILE: src/lmss_csr.sv
// Column pattern registers written through the configuration port.
`default_nettype none

module lmss_csr
   import lmss_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [INDEX_W-1:0]   csr_index,
   input  wire logic [PIXEL_W-1:0]   csr_write_data,
   output pattern_array_type         patterns
);

   pattern_array_type pattern_ff;
   pattern_array_type pattern_in;

   always_comb begin
      pattern_in = pattern_ff;
      if (csr_write_enable && (int'(csr_index) < MATRIX_SIZE)) begin
         pattern_in[csr_index[COL_W-1:0]] = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PATTERN_RESET;
      end else begin
         pattern_ff <= pattern_in;
      end
   end

   assign patterns = pattern_ff;

endmodule

`default_nettype wire

FILE: src/lmss_core.sv
// Column, dwell and scroll counters with the shifted row pattern for each tick.
`default_nettype none

module lmss_core
   import lmss_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              scan_tick,
   input  pattern_array_type      patterns,
   output result_type             result
);

   logic [COL_W-1:0]             column_ff, column_in;
   logic [DWELL_W-1:0]           dwell_ff, dwell_in;
   logic signed [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [PIXEL_W-1:0]           pattern;
   logic [PIXEL_W-1:0]           shown;
   logic [COL_W-1:0]             magnitude;

   always_comb begin
      column_in = column_ff;
      dwell_in  = dwell_ff;
      offset_in = offset_ff;
      if (accept && scan_tick) begin
         column_in = (column_ff == LAST_COLUMN) ? '0 : column_ff + COL_W'(1);
         if (column_in == '0) begin
            dwell_in = dwell_ff - DWELL_W'(1);
         end
         if (dwell_in == '0) begin
            dwell_in  = DWELL_RELOAD;
            offset_in = (offset_ff == MAX_OFFSET) ? MIN_OFFSET
                                                  : offset_ff + OFFSET_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         dwell_ff  <= DWELL_START;
         offset_ff <= '0;
      end else begin
         column_ff <= column_in;
         dwell_ff  <= dwell_in;
         offset_ff <= offset_in;
      end
   end

   assign pattern   = patterns[column_in];
   assign magnitude = offset_in[OFFSET_W-1] ? COL_W'(-offset_in) : COL_W'(offset_in);

   always_comb begin
      if (offset_in[OFFSET_W-1]) begin
         shown = pattern << magnitude;
      end else begin
         shown = pattern >> magnitude;
      end
   end

   always_comb begin
      result.row_drive_n     = ~shown;
      result.column_enable_n = ~(MATRIX_SIZE'(1) << column_in);
      result.active_column   = column_in;
      result.current_offset  = offset_in;
   end

endmodule

`default_nettype wire

FILE: src/lmss_out_buf.sv
// Output register with skid stage for the result channel.
`default_nettype none

module lmss_out_buf
   import lmss_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  result_type  push_data,
   output logic        push_stall,
   output logic        out_valid,
   input  wire logic   out_stall,
   output result_type  out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take || !out_valid_ff) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign push_stall = skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

endmodule

`default_nettype wire

FILE: src/led_matrix_scroll_scanner.sv
// Top level of the scrolling 8x8 LED matrix column scanner.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_scan_tick
//   rsp      out        rsp_valid/rsp_stall  rsp_row_drive_n, rsp_column_enable_n,
//                                            rsp_active_column, rsp_current_offset
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One transaction per cycle while req_stall is low; its result is formed by the
// counter and shift stage and registered in the output register or skid stage.
// Reset zeroes the column and scroll counters, presets dwell, restores the default
// patterns and empties the output. A stalled result is held; one more transaction
// is taken into the skid stage, then req_stall rises until the output drains.
`default_nettype none

module led_matrix_scroll_scanner
   import lmss_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_scan_tick,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [PIXEL_W-1:0]               rsp_row_drive_n,
   output logic [MATRIX_SIZE-1:0]           rsp_column_enable_n,
   output logic [COL_W-1:0]                 rsp_active_column,
   output logic signed [OFFSET_W-1:0]       rsp_current_offset,
   input  wire logic                        csr_write_enable,
   input  wire logic [INDEX_W-1:0]          csr_index,
   input  wire logic [PIXEL_W-1:0]          csr_write_data
);

   pattern_array_type patterns;
   result_type        result;
   result_type        rsp_data;
   logic              accept;

   assign accept = req_valid && !req_stall;

   lmss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .patterns         (patterns)
   );

   lmss_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .scan_tick (req_scan_tick),
      .patterns  (patterns),
      .result    (result)
   );

   lmss_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (result),
      .push_stall (req_stall),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data)
   );

   assign rsp_row_drive_n     = rsp_data.row_drive_n;
   assign rsp_column_enable_n = rsp_data.column_enable_n;
   assign rsp_active_column   = rsp_data.active_column;
   assign rsp_current_offset  = rsp_data.current_offset;

`ifndef ASSERT_OFF
   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid stage full while output register empty");

   a_accept_gives_output: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_enable_one_hot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(~rsp_column_enable_n))
      else $error("column enables not one-hot active low");

   a_enable_matches_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_column_enable_n[rsp_active_column])
      else $error("enabled column differs from active column");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_current_offset != 4'sb1000))
      else $error("scroll offset out of range");
`endif

endmodule

`default_nettype wire

FILE: bench/led_matrix_scroll_scanner_checker.sv
// Scoreboard for the LED matrix scroll scanner: predicts every scan result and compares it.
module led_matrix_scroll_scanner_checker
   import lmss_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire logic                     req_scan_tick,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire logic [PIXEL_W-1:0]       rsp_row_drive_n,
   input  wire logic [MATRIX_SIZE-1:0]   rsp_column_enable_n,
   input  wire logic [COL_W-1:0]         rsp_active_column,
   input  wire logic signed [OFFSET_W-1:0] rsp_current_offset,
   input  wire logic                     csr_write_enable,
   input  wire logic [INDEX_W-1:0]       csr_index,
   input  wire logic [PIXEL_W-1:0]       csr_write_data,
   output int                            fail_count,
   output int                            pending_count,
   output int                            checked_count
);

   logic [PIXEL_W-1:0] column_bytes [MATRIX_SIZE];
   logic [COL_W-1:0]   column_now;
   logic [DWELL_W-1:0] dwell_now;
   int                 scroll_now;
   result_type         expected_scans [$];

   task automatic advance_scan(input logic tick);
      logic [PIXEL_W-1:0] lit;
      result_type         res;
      if (tick) begin
         column_now = column_now + 1'b1;
         if (column_now == '0) dwell_now = dwell_now - 1'b1;
         if (dwell_now == '0) begin
            scroll_now++;
            dwell_now = DWELL_RELOAD;
         end
         if (scroll_now > int'(MAX_OFFSET)) scroll_now = int'(MIN_OFFSET);
      end
      if (scroll_now >= 0) begin
         lit = column_bytes[column_now] >> scroll_now;
      end else begin
         lit = column_bytes[column_now] << (-scroll_now);
      end
      res.row_drive_n     = ~lit;
      res.column_enable_n = ~(MATRIX_SIZE'(1) << column_now);
      res.active_column   = column_now;
      res.current_offset  = OFFSET_W'(scroll_now);
      expected_scans.push_back(res);
   endtask

   task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         for (int i = 0; i < MATRIX_SIZE; i++) column_bytes[i] = PATTERN_RESET[i];
         column_now    = '0;
         dwell_now     = DWELL_START;
         scroll_now    = 0;
         expected_scans.delete();
         fail_count    = 0;
         pending_count = 0;
         checked_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scans.size() == 0) begin
               fail_count++;
               $display("%0t: result with nothing expected, rows %h columns %h", $time,
                        rsp_row_drive_n, rsp_column_enable_n);
            end else begin
               want = expected_scans.pop_front();
               checked_count++;
               compare_field("row_drive_n", want.row_drive_n, rsp_row_drive_n);
               compare_field("column_enable_n", want.column_enable_n, rsp_column_enable_n);
               compare_field("active_column", 8'(want.active_column), 8'(rsp_active_column));
               compare_field("current_offset", 8'(want.current_offset),
                             8'(rsp_current_offset));
            end
         end
         if (req_valid && !req_stall) advance_scan(req_scan_tick);
         if (csr_write_enable && csr_index < MATRIX_SIZE) begin
            column_bytes[csr_index[COL_W-1:0]] = csr_write_data;
         end
         pending_count = expected_scans.size();
      end
   end

endmodule

FILE: bench/led_matrix_scroll_scanner_tb.sv
// Testbench top for the LED matrix scroll scanner: drives scan ticks, pattern writes, verdict.
module led_matrix_scroll_scanner_tb;
   import lmss_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_scan_tick;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [PIXEL_W-1:0]            rsp_row_drive_n;
   logic [MATRIX_SIZE-1:0]        rsp_column_enable_n;
   logic [COL_W-1:0]              rsp_active_column;
   logic signed [OFFSET_W-1:0]    rsp_current_offset;
   logic                          csr_write_enable;
   logic [INDEX_W-1:0]            csr_index;
   logic [PIXEL_W-1:0]            csr_write_data;

   int                            fail_count;
   int                            pending_count;
   int                            checked_count;
   int                            pattern_sets = 0;
   int                            held_ticks = 0;
   bit                            quiet = 1'b1;
   logic [PIXEL_W-1:0]            next_columns [MATRIX_SIZE];

   always #6 clock = ~clock;

   led_matrix_scroll_scanner dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_scan_tick       (req_scan_tick),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_drive_n     (rsp_row_drive_n),
      .rsp_column_enable_n (rsp_column_enable_n),
      .rsp_active_column   (rsp_active_column),
      .rsp_current_offset  (rsp_current_offset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   led_matrix_scroll_scanner_checker scan_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_scan_tick       (req_scan_tick),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_row_drive_n     (rsp_row_drive_n),
      .rsp_column_enable_n (rsp_column_enable_n),
      .rsp_active_column   (rsp_active_column),
      .rsp_current_offset  (rsp_current_offset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .fail_count          (fail_count),
      .pending_count       (pending_count),
      .checked_count       (checked_count)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_scan(input logic tick);
      int gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_scan_tick <= tick;
      do @(posedge clock); while (req_stall);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid     <= 1'b0;
         req_scan_tick <= 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic load_columns(input int strays);
      for (int i = 0; i < MATRIX_SIZE; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= INDEX_W'(i);
         csr_write_data   <= next_columns[i];
      end
      // stray writes above the last column must leave the patterns alone
      repeat (strays) begin
         @(negedge clock);
         csr_index      <= INDEX_W'($urandom_range(MATRIX_SIZE, 2**INDEX_W - 1));
         csr_write_data <= PIXEL_W'($urandom);
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      pattern_sets++;
   endtask

   initial begin : rsp_pacing
      int run;
      int hold;
      rsp_stall = 1'b0;
      forever begin
         run = pick_gap();
         repeat (run + 1) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         hold = quiet ? 0 : pick_gap();
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic tick;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_scan_tick    = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // reset patterns, held tick on either side of a few advances
      send_scan(1'b0);
      repeat (4) send_scan(1'b1);
      send_scan(1'b0);
      wait_drained();

      next_columns = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};
      load_columns(2);
      for (int i = 0; i < 14; i++) send_scan(i != 7);

      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         for (int c = 0; c < MATRIX_SIZE; c++) begin
            next_columns[c] = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : PIXEL_W'($urandom);
         end
         load_columns($urandom_range(0, 3));
         quiet = (phase == 3);
         repeat (300) begin
            tick = ($urandom_range(0, 9) != 0);
            if (!tick) held_ticks++;
            send_scan(tick);
            if (!quiet && $urandom_range(0, 199) == 0) wait_drained();
         end
      end
      quiet = 1'b0;

      wait_drained();
      repeat (4) @(posedge clock);
      $display("Checked %0d scan results over %0d pattern sets; %0d ticks held low, %0d failures.",
               checked_count, pattern_sets, held_ticks, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
src/lmss_pkg.sv
src/lmss_csr.sv
src/lmss_core.sv
src/lmss_out_buf.sv
src/led_matrix_scroll_scanner.sv
bench/led_matrix_scroll_scanner_checker.sv
bench/led_matrix_scroll_scanner_tb.sv
